// File: rtl/wss_pkg.sv
`default_nettype none
package wss_pkg;

  localparam int DEPTH     = 1024;
  localparam int WORD_BITS = 64;
  localparam int IDX_BITS  = 10;
  localparam int ADDR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  localparam int CMP_BITS  = (CNT_BITS > IDX_BITS) ? CNT_BITS : IDX_BITS;

  typedef enum logic [2:0] {
    ACT_PUSH  = 3'd0,
    ACT_POP   = 3'd1,
    ACT_PEEK  = 3'd2,
    ACT_READ  = 3'd3,
    ACT_WRITE = 3'd4,
    ACT_FIND  = 3'd5,
    ACT_CLEAR = 3'd6
  } act_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RDATA,
    S_SCAN,
    S_RESULT
  } state_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_TOP,
    RD_INDEX,
    RD_FIRST,
    RD_NEXT
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_PUSH,
    WR_INDEX
  } wr_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_ZERO
  } cnt_op_t;

  typedef struct packed {
    logic    load_req;
    logic    clear_result;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    cnt_op_t cnt_op;
    logic    take_rdata;
    logic    take_found;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    act_t    action;
    status_t err;
    logic    count_zero;
    logic    match;
    logic    scan_last;
    logic    out_free;
  } stat_t;

endpackage
`default_nettype wire

// File: rtl/wss_ctrl.sv
`default_nettype none
module wss_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  wss_pkg::stat_t stat,
  output wss_pkg::cmd_t  cmd
);
  import wss_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    in_ready         = 1'b0;
    cmd              = '0;
    cmd.rd_sel       = RD_NONE;
    cmd.wr_sel       = WR_NONE;
    cmd.cnt_op       = CNT_HOLD;
    case (state)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.clear_result = 1'b1;
        state_next       = S_RESULT;
        if (stat.err == ST_OK) begin
          case (stat.action)
            ACT_PUSH: begin
              cmd.wr_sel = WR_PUSH;
              cmd.cnt_op = CNT_INC;
            end
            ACT_POP: begin
              cmd.rd_sel = RD_TOP;
              cmd.cnt_op = CNT_DEC;
              state_next = S_RDATA;
            end
            ACT_PEEK: begin
              cmd.rd_sel = RD_TOP;
              state_next = S_RDATA;
            end
            ACT_READ: begin
              cmd.rd_sel = RD_INDEX;
              state_next = S_RDATA;
            end
            ACT_WRITE: begin
              cmd.wr_sel = WR_INDEX;
            end
            ACT_FIND: begin
              if (!stat.count_zero) begin
                cmd.rd_sel = RD_FIRST;
                state_next = S_SCAN;
              end
            end
            ACT_CLEAR: begin
              cmd.cnt_op = CNT_ZERO;
            end
            default: begin
              state_next = S_RESULT;
            end
          endcase
        end
      end
      S_RDATA: begin
        cmd.take_rdata = 1'b1;
        state_next     = S_RESULT;
      end
      S_SCAN: begin
        if (stat.match) begin
          cmd.take_found = 1'b1;
          state_next     = S_RESULT;
        end else if (stat.scan_last) begin
          state_next = S_RESULT;
        end else begin
          cmd.rd_sel = RD_NEXT;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/wss_dp.sv
`default_nettype none
module wss_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          action,
  input  logic signed [63:0]  value,
  input  logic [9:0]          index,
  input  wss_pkg::cmd_t       cmd,
  output wss_pkg::stat_t      stat,
  input  logic                out_ready,
  output logic                out_valid,
  output logic signed [63:0]  data,
  output logic                found,
  output logic [10:0]         count,
  output logic                empty_res,
  output logic [1:0]          status
);
  import wss_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata;
  logic [ADDR_BITS-1:0] mem_addr;
  logic                 mem_we;
  logic                 mem_re;

  act_t                 req_action;
  logic [WORD_BITS-1:0] req_key;
  logic [IDX_BITS-1:0]  req_index;

  logic [CNT_BITS-1:0]  live_count;
  logic [CNT_BITS-1:0]  live_count_next;
  logic [CNT_BITS-1:0]  scan_ptr;

  logic [63:0]          res_data;
  logic                 res_found;
  status_t              res_status;
  status_t              err;
  logic                 idx_bad;
  logic                 is_full;
  logic                 is_empty;

  logic [63:0]          out_data;
  logic                 out_found;
  logic [CNT_BITS-1:0]  out_count;
  status_t              out_status;

  assign is_full  = (live_count == CNT_BITS'(DEPTH));
  assign is_empty = (live_count == '0);
  assign idx_bad  = (CMP_BITS'(req_index) >= CMP_BITS'(live_count));

  always_comb begin
    case (req_action)
      ACT_PUSH:  err = is_full ? ST_FULL : ST_OK;
      ACT_POP,
      ACT_PEEK:  err = is_empty ? ST_EMPTY : ST_OK;
      ACT_READ,
      ACT_WRITE: err = idx_bad ? ST_BADIDX : ST_OK;
      default:   err = ST_OK;
    endcase
  end

  always_comb begin
    stat.action     = req_action;
    stat.err        = err;
    stat.count_zero = is_empty;
    stat.match      = (rdata == req_key);
    stat.scan_last  = (scan_ptr == live_count);
    stat.out_free   = !out_valid || out_ready;
  end

  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = '0;
    case (cmd.wr_sel)
      WR_PUSH: begin
        mem_we   = 1'b1;
        mem_addr = live_count[ADDR_BITS-1:0];
      end
      WR_INDEX: begin
        mem_we   = 1'b1;
        mem_addr = ADDR_BITS'(req_index);
      end
      default: begin
      end
    endcase
    case (cmd.rd_sel)
      RD_TOP: begin
        mem_re   = 1'b1;
        mem_addr = ADDR_BITS'(live_count - 1'b1);
      end
      RD_INDEX: begin
        mem_re   = 1'b1;
        mem_addr = ADDR_BITS'(req_index);
      end
      RD_FIRST: begin
        mem_re   = 1'b1;
        mem_addr = '0;
      end
      RD_NEXT: begin
        mem_re   = 1'b1;
        mem_addr = scan_ptr[ADDR_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= req_key;
    end
    if (mem_re) begin
      rdata <= mem[mem_addr];
    end
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_INC:  live_count_next = live_count + 1'b1;
      CNT_DEC:  live_count_next = live_count - 1'b1;
      CNT_ZERO: live_count_next = '0;
      default:  live_count_next = live_count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      live_count <= live_count_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_action <= act_t'(action);
      req_key    <= value[WORD_BITS-1:0];
      req_index  <= index;
    end
    if (cmd.rd_sel == RD_FIRST) begin
      scan_ptr <= CNT_BITS'(1);
    end else if (cmd.rd_sel == RD_NEXT) begin
      scan_ptr <= scan_ptr + 1'b1;
    end
    if (cmd.clear_result) begin
      res_data   <= '0;
      res_found  <= 1'b0;
      res_status <= err;
    end
    if (cmd.take_rdata) begin
      res_data <= 64'($signed(rdata));
    end
    if (cmd.take_found) begin
      res_found <= 1'b1;
    end
    if (cmd.load_out) begin
      out_data   <= res_data;
      out_found  <= res_found;
      out_count  <= live_count;
      out_status <= res_status;
    end
  end

  assign data      = out_data;
  assign found     = out_found;
  assign count     = 11'(out_count);
  assign empty_res = (out_count == '0);
  assign status    = out_status;

endmodule
`default_nettype wire

// File: rtl/word_stack_with_search_core.sv
`default_nettype none
// Last-in-first-out store of 1024 words of 64 bits with push, pop, peek, read and write
// at an index counted from the bottom, key search and clear; every input beat yields
// exactly one output beat carrying the data, the found flag, the live count, an empty
// flag and a status code. The words sit in a single-port memory with a registered
// read: push, write, clear and any flagged error pass from the decode state straight
// to the result state, pop, peek and read pass through a read-data state between them,
// and find scans the live entries from the bottom, stopping at the first match. A new
// input beat is taken as soon as the previous one is finished, even while its output
// beat still waits to be taken.
module word_stack_with_search_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         action,
  input  logic signed [63:0] value,
  input  logic [9:0]         index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] data,
  output logic               found,
  output logic [10:0]        count,
  output logic               empty_res,
  output logic [1:0]         status
);
  import wss_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  wss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wss_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .action    (action),
    .value     (value),
    .index     (index),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .data      (data),
    .found     (found),
    .count     (count),
    .empty_res (empty_res),
    .status    (status)
  );

endmodule
`default_nettype wire

// File: dv/tb.sv
`default_nettype none
module tb;
  import wss_pkg::*;

  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam int RUN_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 400;

  typedef enum {TR_GROW, TR_SHRINK, TR_MIXED} traffic_t;

  typedef struct {
    logic [63:0] data;
    logic        found;
    logic [10:0] count;
    logic        empty;
    status_t     status;
  } stack_result_t;

  class stack_mirror;
    logic [63:0]   words [DEPTH];
    int unsigned   live;
    int unsigned   mismatches;
    stack_result_t pending [$];

    function new();
      live = 0;
      mismatches = 0;
    endfunction

    function void note_request(logic [2:0] act, logic [63:0] val, logic [9:0] idx);
      stack_result_t r;
      r.data = '0;
      r.found = 1'b0;
      r.status = ST_OK;
      case (act)
        ACT_PUSH: begin
          if (live >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            words[live] = val;
            live++;
          end
        end
        ACT_POP: begin
          if (live == 0) begin
            r.status = ST_EMPTY;
          end else begin
            live--;
            r.data = words[live];
          end
        end
        ACT_PEEK: begin
          if (live == 0) r.status = ST_EMPTY;
          else r.data = words[live - 1];
        end
        ACT_READ: begin
          if (idx >= live) r.status = ST_BADIDX;
          else r.data = words[idx];
        end
        ACT_WRITE: begin
          if (idx >= live) r.status = ST_BADIDX;
          else words[idx] = val;
        end
        ACT_FIND: begin
          for (int i = 0; i < live; i++) begin
            if (words[i] == val) begin
              r.found = 1'b1;
              break;
            end
          end
        end
        ACT_CLEAR: begin
          live = 0;
        end
        default: begin
        end
      endcase
      r.count = 11'(live);
      r.empty = (live == 0);
      pending.push_back(r);
    endfunction

    function void check_response(logic [63:0] got_data, logic got_found,
                                 logic [10:0] got_count, logic got_empty,
                                 logic [1:0] got_status);
      stack_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat, data %h count %0d status %0d",
                 $time, got_data, got_count, got_status);
        mismatches++;
        return;
      end
      exp_r = pending.pop_front();
      if (got_data !== exp_r.data) begin
        $display("%0t: data expected %h actual %h", $time, exp_r.data, got_data);
        mismatches++;
      end
      if (got_found !== exp_r.found) begin
        $display("%0t: found expected %b actual %b", $time, exp_r.found, got_found);
        mismatches++;
      end
      if (got_count !== exp_r.count) begin
        $display("%0t: count expected %0d actual %0d", $time, exp_r.count, got_count);
        mismatches++;
      end
      if (got_empty !== exp_r.empty) begin
        $display("%0t: empty_res expected %b actual %b", $time, exp_r.empty, got_empty);
        mismatches++;
      end
      if (got_status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got_status);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         action = '0;
  logic signed [63:0] value = '0;
  logic [9:0]         index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [63:0] data;
  logic               found;
  logic [10:0]        count;
  logic               empty_res;
  logic [1:0]         status;

  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   tx_idle_pct = 32;
  int   rx_idle_pct = 55;
  int   cycle_count;

  stack_mirror mirror;

  word_stack_with_search_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .value     (value),
    .index     (index),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data      (data),
    .found     (found),
    .count     (count),
    .empty_res (empty_res),
    .status    (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A requested hold-off keeps the output stalled long enough for the input side to back up.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      mirror.check_response(data, found, count, empty_res, status);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(9))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return '0;
      3: return '1;
      4, 5: return 64'($urandom_range(15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_beat(logic [2:0] act, logic [63:0] val, logic [9:0] idx);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    value <= val;
    index <= idx;
    do @(posedge clk); while (!in_ready);
    mirror.note_request(act, val, idx);
  endtask

  task automatic run_traffic(int n_items, int hold_at);
    traffic_t    mode;
    int          seg_left;
    int          live;
    int          push_w;
    int          pop_w;
    int          pick;
    logic [2:0]  act;
    logic [63:0] val;
    logic [9:0]  idx;
    mode = TR_MIXED;
    seg_left = 0;
    for (int n = 0; n < n_items; n++) begin
      if (n == hold_at) hold_req <= hold_req + 1;
      if (seg_left == 0) begin
        mode = traffic_t'($urandom_range(2));
        seg_left = $urandom_range(60, 15);
      end
      seg_left--;
      live = mirror.live;
      if (live > 240) mode = TR_SHRINK;
      push_w = (mode == TR_GROW) ? 55 : (mode == TR_SHRINK) ? 15 : 30;
      pop_w = (mode == TR_GROW) ? 8 : (mode == TR_SHRINK) ? 45 : 22;
      pick = $urandom_range(99);
      if (pick < push_w) begin
        act = ACT_PUSH;
      end else if (pick < push_w + pop_w) begin
        act = ACT_POP;
      end else begin
        pick = $urandom_range(99);
        if (pick < 15) act = ACT_PEEK;
        else if (pick < 35) act = ACT_READ;
        else if (pick < 55) act = ACT_WRITE;
        else if (pick < 80) act = ACT_FIND;
        else if (pick < 88) act = ACT_CLEAR;
        else act = ACT_UNUSED;
      end
      val = rand_word();
      if (act == ACT_FIND && live != 0 && $urandom_range(99) < 60) begin
        val = mirror.words[$urandom_range(live - 1)];
      end
      pick = $urandom_range(9);
      if (live != 0 && pick < 8) idx = 10'($urandom_range(live - 1));
      else if (pick == 8) idx = 10'(live);
      else idx = 10'($urandom);
      send_beat(act, val, idx);
    end
  endtask

  task automatic fill_and_probe();
    logic [63:0] top_word;
    while (mirror.live < DEPTH) send_beat(ACT_PUSH, rand_word(), 10'($urandom));
    repeat (3) send_beat(ACT_PUSH, rand_word(), 10'($urandom));
    top_word = mirror.words[DEPTH - 1];
    send_beat(ACT_PEEK, rand_word(), 10'd0);
    send_beat(ACT_READ, rand_word(), 10'd1023);
    send_beat(ACT_READ, rand_word(), 10'd0);
    send_beat(ACT_WRITE, ~top_word, 10'd1023);
    send_beat(ACT_FIND, top_word, 10'd0);
    send_beat(ACT_FIND, ~top_word, 10'd0);
    send_beat(ACT_POP, rand_word(), 10'd0);
    send_beat(ACT_PUSH, rand_word(), 10'd0);
    send_beat(ACT_CLEAR, rand_word(), 10'd0);
    send_beat(ACT_FIND, top_word, 10'd0);
  endtask

  initial begin
    mirror = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_beat(ACT_POP, 64'd0, 10'd0);
    send_beat(ACT_PEEK, 64'd0, 10'd0);
    send_beat(ACT_READ, 64'd0, 10'd0);
    send_beat(ACT_WRITE, 64'd1, 10'd1023);
    send_beat(ACT_FIND, 64'd0, 10'd0);
    send_beat(ACT_UNUSED, '1, 10'd1023);
    send_beat(ACT_CLEAR, 64'd0, 10'd0);
    send_beat(ACT_PUSH, 64'h8000_0000_0000_0000, 10'd0);
    send_beat(ACT_PUSH, 64'h7fff_ffff_ffff_ffff, 10'd0);
    send_beat(ACT_PUSH, 64'd0, 10'd0);
    send_beat(ACT_PUSH, '1, 10'd0);
    send_beat(ACT_PEEK, 64'd0, 10'd0);
    send_beat(ACT_READ, 64'd0, 10'd0);
    send_beat(ACT_READ, 64'd0, 10'd3);
    send_beat(ACT_READ, 64'd0, 10'd4);
    send_beat(ACT_READ, 64'd0, 10'd1023);
    send_beat(ACT_WRITE, 64'h5555_5555_5555_5555, 10'd1);
    send_beat(ACT_WRITE, 64'haaaa_aaaa_aaaa_aaaa, 10'd4);
    send_beat(ACT_READ, 64'd0, 10'd1);
    send_beat(ACT_FIND, '1, 10'd0);
    send_beat(ACT_FIND, 64'h1234, 10'd0);
    send_beat(ACT_UNUSED, 64'd0, 10'd0);
    send_beat(ACT_POP, 64'd0, 10'd0);
    send_beat(ACT_CLEAR, 64'd0, 10'd0);
    send_beat(ACT_POP, 64'd0, 10'd0);

    run_traffic(350, 20);
    tx_idle_pct = 55;
    rx_idle_pct <= 32;
    run_traffic(350, -1);
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    run_traffic(150, 40);
    fill_and_probe();

    in_valid <= 1'b0;
    while (mirror.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mirror.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
